>>> hdl/assert_macros.svh
// shared assertion macros for the string decoder checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge outside reset
`define JSU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define JSU_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

>>> hdl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    localparam int CP_W = 21;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ERR_UNTERM    = 3'd2;
    localparam logic [2:0] ERR_ESC_SHORT = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd5;
    localparam logic [2:0] ERR_NO_LOW    = 3'd6;
    localparam logic [2:0] ERR_BAD_LOW   = 3'd7;

    // one decoded event from one input word
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      err;
        logic            raw;   // byte passes through as is, no utf-8 expansion
        logic [CP_W-1:0] cp;
    } job_t;

endpackage

`default_nettype wire

>>> hdl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    input  wire logic       take,
    output logic            push,
    output job_t            job
);

    localparam logic [2:0] ST_AWAIT   = 3'd0;
    localparam logic [2:0] ST_BODY    = 3'd1;
    localparam logic [2:0] ST_ESC     = 3'd2;
    localparam logic [2:0] ST_HEX     = 3'd3;
    localparam logic [2:0] ST_WANT_BS = 3'd4;
    localparam logic [2:0] ST_WANT_U  = 3'd5;
    localparam logic [2:0] ST_HEX_LOW = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [5:0] HI_SURR_TOP = 6'b110110;
    localparam logic [5:0] LO_SURR_TOP = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hi_reg, hi_next;
    logic        emit;
    logic [4:0]  digit;
    logic [15:0] acc_shift;

    // bit 4 set marks a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                v = {1'b0, c[3:0]};
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                v = {1'b0, c[3:0] + 4'd9};
            else
                v = 5'h10;
            return v;
        end
    endfunction

    assign digit     = hex_value(in_byte);
    assign acc_shift = {acc_reg[11:0], digit[3:0]};
    assign push      = take && emit;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        hi_next    = hi_reg;
        emit       = 1'b0;
        job.kind   = KIND_BYTE;
        job.err    = ERR_NONE;
        job.raw    = 1'b0;
        job.cp     = {{(CP_W-8){1'b0}}, in_byte};

        unique case (state_reg)
            ST_BODY:
            begin
                if (end_of_text)
                begin
                    emit     = 1'b1;
                    job.kind = KIND_ERROR;
                    job.err  = ERR_UNTERM;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    emit       = 1'b1;
                    job.kind   = KIND_CLOSE;
                    state_next = ST_AWAIT;
                end
                else if (in_byte == CH_BSL)
                    state_next = ST_ESC;
                else
                begin
                    emit    = 1'b1;
                    job.raw = 1'b1;
                end
            end
            ST_ESC:
            begin
                state_next = ST_BODY;
                emit       = 1'b1;
                if (end_of_text)
                begin
                    job.kind = KIND_ERROR;
                    job.err  = ERR_ESC_SHORT;
                end
                else
                begin
                    unique case (in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: job.cp = {{(CP_W-8){1'b0}}, in_byte};
                        CH_B: job.cp = 21'h08;
                        CH_F: job.cp = 21'h0C;
                        CH_N: job.cp = 21'h0A;
                        CH_R: job.cp = 21'h0D;
                        CH_T: job.cp = 21'h09;
                        CH_U:
                        begin
                            emit       = 1'b0;
                            state_next = ST_HEX;
                            cnt_next   = 2'd0;
                            acc_next   = 16'h0;
                        end
                        default:
                        begin
                            job.kind = KIND_ERROR;
                            job.err  = ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            ST_HEX, ST_HEX_LOW:
            begin
                if (end_of_text)
                begin
                    emit     = 1'b1;
                    job.kind = KIND_ERROR;
                    job.err  = (state_reg == ST_HEX) ? ERR_ESC_SHORT : ERR_NO_LOW;
                end
                else if (digit[4])
                begin
                    emit     = 1'b1;
                    job.kind = KIND_ERROR;
                    job.err  = ERR_BAD_HEX;
                end
                else if (cnt_reg != 2'd3)
                begin
                    cnt_next = cnt_reg + 2'd1;
                    acc_next = acc_shift;
                end
                else
                begin
                    // fourth digit completes the value
                    cnt_next = 2'd0;
                    acc_next = 16'h0;
                    if (state_reg == ST_HEX)
                    begin
                        if (acc_shift[15:10] == HI_SURR_TOP)
                        begin
                            hi_next    = acc_shift[9:0];
                            state_next = ST_WANT_BS;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            job.cp     = {{(CP_W-16){1'b0}}, acc_shift};
                            state_next = ST_BODY;
                        end
                    end
                    else if (acc_shift[15:10] != LO_SURR_TOP)
                    begin
                        emit     = 1'b1;
                        job.kind = KIND_ERROR;
                        job.err  = ERR_BAD_LOW;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        job.cp     = SUPP_BASE + {1'b0, hi_reg, acc_shift[9:0]};
                        hi_next    = 10'h0;
                        state_next = ST_BODY;
                    end
                end
            end
            ST_WANT_BS:
            begin
                if (end_of_text || in_byte != CH_BSL)
                begin
                    emit     = 1'b1;
                    job.kind = KIND_ERROR;
                    job.err  = ERR_NO_LOW;
                end
                else
                    state_next = ST_WANT_U;
            end
            ST_WANT_U:
            begin
                if (end_of_text || in_byte != CH_U)
                begin
                    emit     = 1'b1;
                    job.kind = KIND_ERROR;
                    job.err  = ERR_NO_LOW;
                end
                else
                begin
                    state_next = ST_HEX_LOW;
                    cnt_next   = 2'd0;
                    acc_next   = 16'h0;
                end
            end
            default:
            begin
                state_next = ST_AWAIT;
                if (!end_of_text)
                begin
                    if (in_byte == CH_QUOTE)
                        state_next = ST_BODY;
                    else
                    begin
                        emit     = 1'b1;
                        job.kind = KIND_ERROR;
                        job.err  = ERR_NO_QUOTE;
                    end
                end
            end
        endcase

        // any error drops back to waiting for a quote
        if (emit && job.kind == KIND_ERROR)
        begin
            state_next = ST_AWAIT;
            cnt_next   = 2'd0;
            acc_next   = 16'h0;
            hi_next    = 10'h0;
        end
        if (job.kind != KIND_BYTE)
            job.cp = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_AWAIT;
            cnt_reg   <= 2'd0;
            acc_reg   <= 16'h0;
            hi_reg    <= 10'h0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            hi_reg    <= hi_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/jsu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t wr_job,
    input  wire logic pop,
    output job_t      rd_job,
    output logic      not_empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        begin
            return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    assign rd_job    = slot_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> hdl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire job_t       head,
    input  wire logic       head_valid,
    output logic            pop,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [2:0]      error_code,
    output logic            last_of_run
);

    job_t       job_reg;
    logic       act_reg;
    logic [1:0] idx_reg;
    logic       res_valid_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] kind_reg;
    logic [2:0] err_reg;
    logic       last_reg;
    logic [1:0] len_m1;
    logic       is_last;
    logic       advance;
    logic       load;

    // number of utf-8 bytes minus one
    function automatic logic [1:0] utf8_len_m1(input logic [CP_W-1:0] cp);
        begin
            if (cp[CP_W-1:7] == '0)
                return 2'd0;
            else if (cp[CP_W-1:11] == '0)
                return 2'd1;
            else if (cp[CP_W-1:16] == '0)
                return 2'd2;
            else
                return 2'd3;
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0] lm1,
                                             input logic [1:0] idx);
        logic [7:0] b;
        begin
            b = {2'b10, cp[5:0]};
            unique case (lm1)
                2'd0: b = cp[7:0];
                2'd1:
                begin
                    if (idx == 2'd0)
                        b = {3'b110, cp[10:6]};
                end
                2'd2:
                begin
                    if (idx == 2'd0)
                        b = {4'b1110, cp[15:12]};
                    else if (idx == 2'd1)
                        b = {2'b10, cp[11:6]};
                end
                default:
                begin
                    if (idx == 2'd0)
                        b = {5'b11110, cp[20:18]};
                    else if (idx == 2'd1)
                        b = {2'b10, cp[17:12]};
                    else if (idx == 2'd2)
                        b = {2'b10, cp[11:6]};
                end
            endcase
            return b;
        end
    endfunction

    // raw bytes and markers leave as a single word
    assign len_m1  = (job_reg.kind == KIND_BYTE && !job_reg.raw) ?
                     utf8_len_m1(job_reg.cp) : 2'd0;
    assign is_last = (idx_reg == len_m1);
    assign advance = act_reg && (!res_valid_reg || res_ready);
    assign load    = head_valid && (!act_reg || (advance && is_last));
    assign pop     = load;

    assign res_valid   = res_valid_reg;
    assign out_byte    = out_byte_reg;
    assign kind        = kind_reg;
    assign error_code  = err_reg;
    assign last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            idx_reg       <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                act_reg <= 1'b1;
                idx_reg <= 2'd0;
            end
            else if (advance)
            begin
                if (is_last)
                    act_reg <= 1'b0;
                idx_reg <= idx_reg + 2'd1;
            end
            if (advance)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= head;
        if (advance)
        begin
            out_byte_reg <= (job_reg.kind == KIND_BYTE) ?
                            utf8_byte(job_reg.cp, len_m1, idx_reg) : 8'h00;
            kind_reg     <= job_reg.kind;
            err_reg      <= job_reg.err;
            last_reg     <= is_last;
        end
    end

endmodule

`default_nettype wire

>>> hdl/json_string_unescape_utf8.sv
// path: each job passes through the job queue, the back end job register and its output register
// throughput: one input word per cycle while the four-entry job queue has room
// a code point of N utf-8 bytes holds the output side for all N bytes, so queue fill sets rate
// reset: rst_n is asynchronous, active low; decoder waits for an opening quote, queue empty
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input byte channel
    input  wire logic       src_valid,
    output logic            src_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    // result channel
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [2:0]      error_code,
    output logic            last_of_run
);

    logic take;         // input word accepted this cycle
    logic push;         // front end produced a job
    job_t front_job;
    job_t head_job;
    logic head_valid;
    logic q_full;
    logic pop;

    // the front end only stalls when the job queue is full
    assign src_ready = !q_full;
    assign take      = src_valid && src_ready;

    // parser: tracks quote, escape and \u state, turns each input word
    // into at most one job (code point, raw byte, close marker or error)
    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .take        (take),
        .push        (push),
        .job         (front_job)
    );

    // short queue decouples parsing from utf-8 expansion
    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_job    (front_job),
        .pop       (pop),
        .rd_job    (head_job),
        .not_empty (head_valid),
        .full      (q_full)
    );

    // back end: expands each job into one to four result words through
    // a registered output stage
    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .head_valid  (head_valid),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

>>> hdl/jsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       src_valid,
    input wire logic       src_ready,
    input wire logic [7:0] in_byte,
    input wire logic       end_of_text,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] kind,
    input wire logic [2:0] error_code,
    input wire logic       last_of_run
);

    logic [8:0]  src_word;
    logic [13:0] res_word;

    assign src_word = {in_byte, end_of_text};
    assign res_word = {out_byte, kind, error_code, last_of_run};

    // a stalled input word holds
    `JSU_ASSERT_NEXT(a_src_hold, clk, rst_n, src_valid && !src_ready, src_valid && $stable(src_word), "input word changed while stalled")

    // a stalled result word holds
    `JSU_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_word), "result word changed while stalled")

    // close and error words carry no byte and end their run
    `JSU_ASSERT(a_marker_alone, clk, rst_n, !(res_valid && kind != KIND_BYTE) || (out_byte == 8'h00 && last_of_run), "marker word with byte or not last")

    // an error code is present exactly on error words
    `JSU_ASSERT(a_err_code, clk, rst_n, !res_valid || ((kind == KIND_ERROR) == (error_code != ERR_NONE)), "error code does not match kind")

    // kind takes only its three defined codes
    `JSU_ASSERT(a_kind_legal, clk, rst_n, !res_valid || kind == KIND_BYTE || kind == KIND_CLOSE || kind == KIND_ERROR, "undefined result kind")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire

>>> bench/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;

    import jsu_pkg::*;

    localparam int RANDOM_WORDS = 130;   // rough size of the random part
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off, fills the job queue
    localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int SETTLE       = 12;    // wait after the last result before the final check

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;

    // every single-letter escape, packed eight bits per letter
    localparam logic [63:0] SIMPLE_ESCAPES = {CH_QUOTE, CH_BSLASH, CH_SLASH,
                                              8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

    // where the decoder stands inside a string literal
    typedef enum logic [3:0] {
        DEC_AWAIT,
        DEC_BODY,
        DEC_ESC,
        DEC_HEX,
        DEC_WANT_BS,
        DEC_WANT_U,
        DEC_HEX_LOW
    } decode_phase_e;

    // one raw text word waiting to go out, with a flag to hold it until the
    // decoder has delivered everything predicted so far
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       wait_drain;
    } text_word_t;

    // one predicted result word
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_ready;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last_of_run;

    json_string_unescape_utf8 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // text waiting to be sent and decoded words still owed by the block
    // ------------------------------------------------------------------
    text_word_t text_q[$];
    decoded_t   expected_q[$];

    int words_queued  = 0;
    int words_offered = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int bytes_seen    = 0;
    int closes_seen   = 0;
    int errors_seen   = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    // predictor state, mirrors the decoder
    decode_phase_e dec_phase  = DEC_AWAIT;
    int            dec_digits = 0;
    logic [15:0]   dec_acc    = 16'h0000;
    logic [9:0]    held_high  = 10'h000;

    // first ten problems are printed, the rest only counted
    function automatic void flag_error(string what);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    // 0..15 for a hex digit in either case, 16 for anything else
    function automatic logic [4:0] hex_value(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return 5'(c[3:0] + 4'd9);
        return 5'd16;
    endfunction

    function automatic void add_result(logic [7:0] data, logic [1:0] k, logic [2:0] code);
        decoded_t r;
        r.data = data;
        r.kind = k;
        r.code = code;
        r.last = 1'b0;
        expected_q.insert(expected_q.size(), r);
    endfunction

    // any error drops the string and goes back to hunting for a quote
    function automatic void decode_error(logic [2:0] code);
        dec_phase  = DEC_AWAIT;
        dec_digits = 0;
        dec_acc    = 16'h0000;
        held_high  = 10'h000;
        add_result(8'h00, KIND_ERROR, code);
    endfunction

    // code point to one..four utf-8 bytes
    function automatic void add_utf8(logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            add_result(cp[7:0], KIND_BYTE, ERR_NONE);
        end
        else if (cp <= 21'h7FF)
        begin
            add_result({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end
        else if (cp <= 21'hFFFF)
        begin
            add_result({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end
        else
        begin
            add_result({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
            add_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end
    endfunction

    // advance the predicted decoder by one accepted text word
    function automatic void decode_word(logic [7:0] c, logic eot);
        int          start_idx;
        logic [4:0]  digit;
        logic [15:0] value;
        start_idx = expected_q.size();
        case (dec_phase)
            DEC_BODY:
            begin
                if (eot)
                    decode_error(ERR_UNTERM);
                else if (c == CH_QUOTE)
                begin
                    dec_phase = DEC_AWAIT;
                    add_result(8'h00, KIND_CLOSE, ERR_NONE);
                end
                else if (c == CH_BSLASH)
                    dec_phase = DEC_ESC;
                else
                    add_result(c, KIND_BYTE, ERR_NONE);
            end
            DEC_ESC:
            begin
                if (eot)
                    decode_error(ERR_ESC_SHORT);
                else
                begin
                    dec_phase = DEC_BODY;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(c, KIND_BYTE, ERR_NONE);
                        "b": add_result(8'h08, KIND_BYTE, ERR_NONE);
                        "f": add_result(8'h0C, KIND_BYTE, ERR_NONE);
                        "n": add_result(8'h0A, KIND_BYTE, ERR_NONE);
                        "r": add_result(8'h0D, KIND_BYTE, ERR_NONE);
                        "t": add_result(8'h09, KIND_BYTE, ERR_NONE);
                        CH_U:
                        begin
                            dec_phase  = DEC_HEX;
                            dec_digits = 0;
                            dec_acc    = 16'h0000;
                        end
                        default: decode_error(ERR_BAD_ESC);
                    endcase
                end
            end
            DEC_HEX, DEC_HEX_LOW:
            begin
                digit = hex_value(c);
                if (eot)
                    decode_error(dec_phase == DEC_HEX ? ERR_ESC_SHORT : ERR_NO_LOW);
                else if (digit[4])
                    decode_error(ERR_BAD_HEX);
                else
                begin
                    dec_acc = {dec_acc[11:0], digit[3:0]};
                    dec_digits++;
                    if (dec_digits == 4)
                    begin
                        value      = dec_acc;
                        dec_digits = 0;
                        dec_acc    = 16'h0000;
                        if (dec_phase == DEC_HEX)
                        begin
                            if (value >= 16'hD800 && value <= 16'hDBFF)
                            begin
                                held_high = value[9:0];
                                dec_phase = DEC_WANT_BS;
                            end
                            else
                            begin
                                dec_phase = DEC_BODY;
                                add_utf8({5'd0, value});
                            end
                        end
                        else if (value < 16'hDC00 || value > 16'hDFFF)
                            decode_error(ERR_BAD_LOW);
                        else
                        begin
                            dec_phase = DEC_BODY;
                            add_utf8(21'h10000 + {1'b0, held_high, value[9:0]});
                            held_high = 10'h000;
                        end
                    end
                end
            end
            DEC_WANT_BS:
            begin
                if (eot || c != CH_BSLASH)
                    decode_error(ERR_NO_LOW);
                else
                    dec_phase = DEC_WANT_U;
            end
            DEC_WANT_U:
            begin
                if (eot || c != CH_U)
                    decode_error(ERR_NO_LOW);
                else
                begin
                    dec_phase  = DEC_HEX_LOW;
                    dec_digits = 0;
                    dec_acc    = 16'h0000;
                end
            end
            default:
            begin
                // end of text while idle is silently dropped
                dec_phase = DEC_AWAIT;
                if (!eot)
                begin
                    if (c == CH_QUOTE)
                        dec_phase = DEC_BODY;
                    else
                        decode_error(ERR_NO_QUOTE);
                end
            end
        endcase
        if (expected_q.size() > start_idx)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic void push_word(logic [7:0] ch, logic eot);
        text_word_t w;
        w.ch         = ch;
        w.eot        = eot;
        w.wait_drain = 1'b0;
        text_q.insert(text_q.size(), w);
        words_queued++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(s[i], 1'b0);
    endfunction

    // leading hex digits of v, each digit in a random case
    function automatic void push_hex_digits(logic [15:0] v, int count);
        logic [3:0] nib;
        for (int i = 0; i < count; i++)
        begin
            nib = v[15 - 4 * i -: 4];
            if (nib < 4'd10)
                push_word(8'h30 + nib, 1'b0);
            else
                push_word(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10, 1'b0);
        end
    endfunction

    function automatic void push_high_escape();
        push_text("\\u");
        push_hex_digits(16'hD800 | 16'($urandom_range(0, 1023)), 4);
    endfunction

    // one malformed escape; the string is dead after it
    function automatic void push_broken_escape();
        logic [7:0]  b;
        logic [15:0] v;
        b = 8'($urandom);
        case ($urandom_range(0, 8))
            0:
            begin
                // unknown escape letter
                for (int k = 0; k < 8; k++)
                    if (b == SIMPLE_ESCAPES[8 * k +: 8])
                        b = "q";
                if (b == CH_U)
                    b = "q";
                push_word(CH_BSLASH, 1'b0);
                push_word(b, 1'b0);
            end
            1:
            begin
                // non-hex inside the digits
                push_text("\\u");
                push_hex_digits(16'($urandom), $urandom_range(0, 3));
                if (hex_value(b) < 5'd16)
                    b = "g";
                push_word(b, 1'b0);
            end
            2:
            begin
                push_word(CH_BSLASH, 1'b0);
                push_word(b, 1'b1);
            end
            3:
            begin
                push_text("\\u");
                push_hex_digits(16'($urandom), $urandom_range(0, 3));
                push_word(b, 1'b1);
            end
            4:
            begin
                // high surrogate followed by something other than a backslash
                push_high_escape();
                if (b == CH_BSLASH)
                    b = CH_QUOTE;
                push_word(b, 1'b0);
            end
            5:
            begin
                push_high_escape();
                push_word(CH_BSLASH, 1'b0);
                if (b == CH_U)
                    b = "n";
                push_word(b, 1'b0);
            end
            6:
            begin
                // text ends somewhere before the low half starts
                push_high_escape();
                case ($urandom_range(0, 2))
                    1: push_text("\\");
                    2: push_text("\\u");
                    default: ;
                endcase
                push_word(b, 1'b1);
            end
            7:
            begin
                // second value is not a low surrogate
                push_high_escape();
                push_text("\\u");
                if ($urandom_range(0, 1))
                    v = 16'($urandom_range(0, 16'hDBFF));
                else
                    v = 16'($urandom_range(16'hE000, 16'hFFFF));
                push_hex_digits(v, 4);
            end
            default:
            begin
                // low half cut short by end of text or a bad digit
                push_high_escape();
                push_text("\\u");
                push_hex_digits(16'hDC00 | 16'($urandom_range(0, 1023)), $urandom_range(0, 3));
                if ($urandom_range(0, 1))
                    push_word(b, 1'b1);
                else
                    push_word("z", 1'b0);
            end
        endcase
    endfunction

    // one string literal with random content, mostly well formed
    function automatic void push_random_string();
        logic [7:0]  b;
        logic [15:0] v;
        bit          broken;
        int          n_tokens;
        int          pick;
        // now and then some junk ahead of the opening quote
        pick = $urandom_range(0, 9);
        b    = 8'($urandom);
        if (pick == 0)
            push_word(b == CH_QUOTE ? 8'h00 : b, 1'b0);
        else if (pick == 1)
            push_word(b, 1'b1);
        push_word(CH_QUOTE, 1'b0);
        broken   = 1'b0;
        n_tokens = $urandom_range(1, 6);
        for (int i = 0; i < n_tokens && !broken; i++)
        begin
            pick = $urandom_range(0, 99);
            b    = 8'($urandom);
            if (pick < 35)
            begin
                // raw byte, control bytes and high bytes included
                if (b == CH_QUOTE || b == CH_BSLASH)
                    b = b + 8'd1;
                push_word(b, 1'b0);
            end
            else if (pick < 55)
            begin
                push_word(CH_BSLASH, 1'b0);
                push_word(SIMPLE_ESCAPES[8 * $urandom_range(0, 7) +: 8], 1'b0);
            end
            else if (pick < 75)
            begin
                // single \u value, sized to hit each one- to three-byte utf-8 length
                case ($urandom_range(0, 5))
                    0: v = 16'($urandom_range(0, 16'h7F));
                    1: v = 16'($urandom_range(16'h80, 16'h7FF));
                    2: v = 16'($urandom_range(16'h800, 16'hD7FF));
                    3: v = 16'($urandom_range(16'hE000, 16'hFFFF));
                    4: v = 16'($urandom_range(16'hDC00, 16'hDFFF));   // lone low half
                    default:
                    begin
                        case ($urandom_range(0, 5))
                            0: v = 16'h0000;
                            1: v = 16'h007F;
                            2: v = 16'h0080;
                            3: v = 16'h07FF;
                            4: v = 16'h0800;
                            default: v = 16'hFFFF;
                        endcase
                    end
                endcase
                push_text("\\u");
                push_hex_digits(v, 4);
            end
            else if (pick < 88)
            begin
                // surrogate pair, sometimes at the ends of the range
                case ($urandom_range(0, 5))
                    0: v = 16'h0000;
                    1: v = 16'h03FF;
                    default: v = 16'($urandom_range(0, 1023));
                endcase
                push_text("\\u");
                push_hex_digits(16'hD800 | v, 4);
                push_text("\\u");
                push_hex_digits(16'hDC00 | 16'($urandom_range(0, 1023)), 4);
            end
            else
            begin
                broken = 1'b1;
                push_broken_escape();
            end
        end
        if (!broken)
        begin
            if ($urandom_range(0, 9) == 0)
                push_word(8'($urandom), 1'b1);
            else
                push_word(CH_QUOTE, 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // source driver: offers queued text words, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : text_driver
        text_word_t nxt;
        logic       took;
        logic       offer;
        if (!rst_n)
        begin
            src_valid   <= 1'b0;
            in_byte     <= 8'h00;
            end_of_text <= 1'b0;
        end
        else
        begin
            took = src_valid && src_ready;
            if (took)
            begin
                decode_word(in_byte, end_of_text);
                words_sent++;
            end
            // a word stays up, unchanged, until it is taken
            if (!src_valid || took)
            begin
                offer = text_q.size() > 0
                     && (!text_q[0].wait_drain || expected_q.size() == 0)
                     && ((words_offered >= 60 && words_offered < 110)
                         || $urandom_range(0, 99) >= 33);
                if (offer)
                begin
                    nxt = text_q.pop_front();
                    in_byte     <= nxt.ch;
                    end_of_text <= nxt.eot;
                    words_offered++;
                end
                src_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each taken word, drives the receiver stalls
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        decoded_t want;
        logic     go;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (kind == KIND_BYTE)
                    bytes_seen++;
                else if (kind == KIND_CLOSE)
                    closes_seen++;
                else
                    errors_seen++;
                if (expected_q.size() == 0)
                    flag_error($sformatf("unexpected result word: byte %02h kind %0d code %0d last %0b",
                                         out_byte, kind, error_code, last_of_run));
                else
                begin
                    want = expected_q.pop_front();
                    if (out_byte !== want.data || kind !== want.kind
                        || error_code !== want.code || last_of_run !== want.last)
                        flag_error($sformatf({"result %0d: expected byte %02h kind %0d code %0d ",
                                              "last %0b, got byte %02h kind %0d code %0d last %0b"},
                                             results_seen, want.data, want.kind, want.code,
                                             want.last, out_byte, kind, error_code, last_of_run));
                end
            end
            // one long hold-off early on so the job queue backs up into the source
            if (hold_left > 0)
            begin
                hold_left--;
                go = 1'b0;
            end
            else if (!hold_done && results_seen >= 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                go        = 1'b0;
            end
            else
            begin
                go = (results_seen >= 100 && results_seen < 180) || $urandom_range(0, 99) >= 33;
            end
            res_ready <= go;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: nothing moving on either side for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && src_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] watchdog: no word moved in %0d cycles, %0d results still owed",
                     $time, QUIET_LIMIT, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int directed_words;
        int mark;
        bit mid_marked;

        // directed: stray byte and silent end of text while idle
        push_word(8'hFF, 1'b0);
        push_word(8'hA5, 1'b1);
        // extreme raw bytes, an escape and the closing quote
        push_word(CH_QUOTE, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_text("\\t\"");
        // surrogate pair to a four byte sequence, mixed digit case
        push_text("\"\\uD83d\\uDE00\"");
        // text ends inside the body
        push_word(CH_QUOTE, 1'b0);
        push_word(8'h5A, 1'b1);
        // unknown escape letter
        push_text("\"\\q");
        directed_words = words_queued;

        // random strings; twice the source waits for all results first
        mid_marked = 1'b0;
        mark = text_q.size();
        push_random_string();
        text_q[mark].wait_drain = 1'b1;
        while (words_queued < directed_words + RANDOM_WORDS)
        begin
            mark = text_q.size();
            push_random_string();
            if (!mid_marked && words_queued >= directed_words + RANDOM_WORDS / 2)
            begin
                text_q[mark].wait_drain = 1'b1;
                mid_marked = 1'b1;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (words_sent < words_queued || expected_q.size() != 0);
        repeat (SETTLE) @(negedge clk);

        if (expected_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_q.size()));

        $display("run covered %0d text words and %0d result words", words_sent, results_seen);
        $display("  %0d decoded bytes, %0d closed strings, %0d error reports, %0d mismatches",
                 bytes_seen, closes_seen, errors_seen, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
